// ===== hw/rtl/bfa_pkg.sv =====
// Shared types and constants of the bitmap frame allocator.
// No dependencies; imported by bfa_ctrl, bfa_datapath and bitmap_frame_allocator.
`timescale 1ns / 1ps

package bfa_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned CFG_W  = 13;
  localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = 13'd4096;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_FREE    = 2'd1,
    REQ_RESERVE = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_CHECK,
    S_SCAN,
    S_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic clear;     // zero the word at the pointer, advance
    logic load;      // capture an input word
    logic setup;     // derive word range and bit bounds
    logic rd_first;  // read first word of the range
    logic rd_next;   // read the word after the pointer
    logic eval;      // update the word in the read register
    logic publish;   // move result to the output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;  // pointer at the last bitmap word
    logic empty;     // request touches no frame
    logic at_last;   // word under evaluation is the last of the range
    logic hit;       // allocate found a free frame in this word
    logic out_free;  // output register can take a result
  } dp_status_t;

endpackage

// ===== hw/rtl/bfa_ctrl.sv =====
// Sequencer of the bitmap frame allocator: clearing pass, request setup, word scan.
// Depends on bfa_pkg.
`timescale 1ns / 1ps

module bfa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bfa_pkg::dp_status_t status_i,
  output bfa_pkg::dp_cmd_t    cmd_o
);
  import bfa_pkg::*;

  state_e state_q, state_d;
  logic   scan_done;

  assign scan_done = status_i.at_last | status_i.hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (status_i.clr_last) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_SETUP;
      S_SETUP: state_d = S_CHECK;
      S_CHECK: state_d = status_i.empty ? S_DONE : S_SCAN;
      S_SCAN:  if (scan_done) state_d = S_DONE;
      S_DONE:  if (status_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: cmd_o.clear = 1'b1;
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_SETUP: cmd_o.setup = 1'b1;
      S_CHECK: cmd_o.rd_first = ~status_i.empty;
      S_SCAN: begin
        cmd_o.eval    = 1'b1;
        cmd_o.rd_next = ~scan_done;
      end
      S_DONE: cmd_o.publish = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== hw/rtl/bfa_datapath.sv =====
// Datapath of the bitmap frame allocator: bitmap memory, range setup, word update,
// result and output registers. Depends on bfa_pkg.
`timescale 1ns / 1ps

module bfa_datapath #(
  parameter int unsigned MAX_FRAMES  = 4096,
  parameter int unsigned FRAME_BYTES = 4096,
  parameter int unsigned WORD_BITS   = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bfa_pkg::dp_cmd_t            cmd_i,
  output bfa_pkg::dp_status_t         status_o,
  input  logic [bfa_pkg::REQ_W-1:0]   req_type_i,
  input  logic [bfa_pkg::ADDR_W-1:0]  address_i,
  input  logic [bfa_pkg::ADDR_W-1:0]  length_bytes_i,
  input  logic [bfa_pkg::CFG_W-1:0]   frame_count_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [bfa_pkg::ADDR_W-1:0]  frame_address_o,
  output logic                        granted_o
);
  import bfa_pkg::*;

  localparam int unsigned FB_LOG2   = $clog2(FRAME_BYTES);
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);
  localparam int unsigned MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned SUM_W     = ADDR_W + 2;
  localparam int unsigned FIDX_W    = SUM_W - FB_LOG2;
  localparam int unsigned CNT_W     = $clog2(MAX_FRAMES + 1);
  localparam int unsigned FCMP_W0   = (FIDX_W > CNT_W) ? FIDX_W : CNT_W;
  localparam int unsigned FCMP_W    = (FCMP_W0 > CFG_W) ? FCMP_W0 : CFG_W;
  localparam int unsigned FADDR_W   = WIDX_W + BIT_W + FB_LOG2;
  localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(MAP_WORDS - 1);

  // live frame count, min(frame_count, MAX_FRAMES)
  logic [FCMP_W-1:0] fc_ext, max_c, cnt;
  assign fc_ext = FCMP_W'(frame_count_i);
  assign max_c  = FCMP_W'(MAX_FRAMES);
  assign cnt    = (fc_ext < max_c) ? fc_ext : max_c;

  // request capture
  req_e              req_q;
  logic [FCMP_W-1:0] start_f_q, end_raw_q;
  logic [SUM_W-1:0]  end_sum;

  assign end_sum = SUM_W'(address_i) + SUM_W'(length_bytes_i) + SUM_W'(FRAME_BYTES - 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q     <= req_e'(req_type_i);
      start_f_q <= FCMP_W'(address_i >> FB_LOG2);
      end_raw_q <= FCMP_W'(end_sum >> FB_LOG2);
    end
  end

  // range setup
  logic [FCMP_W-1:0] end_clip, last_f, cnt_m1;
  logic              empty_d;
  logic [WIDX_W-1:0] first_w_d, last_w_d;
  logic [BIT_W-1:0]  lo_d, hi_d;
  logic              empty_q;
  logic [WIDX_W-1:0] first_w_q, last_w_q;
  logic [BIT_W-1:0]  lo_q, hi_q;

  assign end_clip = (end_raw_q < cnt) ? end_raw_q : cnt;
  assign last_f   = end_clip - FCMP_W'(1);
  assign cnt_m1   = cnt - FCMP_W'(1);

  always_comb begin
    empty_d   = 1'b1;
    first_w_d = '0;
    last_w_d  = '0;
    lo_d      = '0;
    hi_d      = '0;
    unique case (req_q)
      REQ_ALLOC: begin
        empty_d  = (cnt == '0);
        last_w_d = WIDX_W'(cnt_m1 >> BIT_W);
        hi_d     = cnt_m1[BIT_W-1:0];
      end
      REQ_FREE: begin
        empty_d   = !(start_f_q < cnt);
        first_w_d = WIDX_W'(start_f_q >> BIT_W);
        last_w_d  = WIDX_W'(start_f_q >> BIT_W);
        lo_d      = start_f_q[BIT_W-1:0];
        hi_d      = start_f_q[BIT_W-1:0];
      end
      REQ_RESERVE: begin
        empty_d   = !(start_f_q < end_clip);
        first_w_d = WIDX_W'(start_f_q >> BIT_W);
        last_w_d  = WIDX_W'(last_f >> BIT_W);
        lo_d      = start_f_q[BIT_W-1:0];
        hi_d      = last_f[BIT_W-1:0];
      end
      default: empty_d = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q <= 1'b1;
    end else if (cmd_i.setup) begin
      empty_q <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      first_w_q <= first_w_d;
      last_w_q  <= last_w_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
    end
  end

  // bitmap memory: one write port, one registered read port
  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic [WIDX_W-1:0]    ptr_q, ptr_d, ptr_inc, rd_addr;
  logic                 rd_en, mem_we;
  logic [WORD_BITS-1:0] mem_wd;

  assign ptr_inc = ptr_q + WIDX_W'(1);
  assign rd_en   = cmd_i.rd_first | cmd_i.rd_next;
  assign rd_addr = cmd_i.rd_first ? first_w_q : ptr_inc;

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.clear) begin
      ptr_d = ptr_inc;
    end else if (rd_en) begin
      ptr_d = rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[ptr_q] <= mem_wd;
    end
  end

  // word update
  logic [WORD_BITS-1:0] act_mask, cand, onehot, upd_word;
  logic [BIT_W-1:0]     idx;
  logic                 found, hit;
  logic [FADDR_W-1:0]   fa_full;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      act_mask[b] = ((ptr_q != first_w_q) || (BIT_W'(b) >= lo_q)) &&
                    ((ptr_q != last_w_q) || (BIT_W'(b) <= hi_q));
    end
  end

  assign cand  = ~rdata_q & act_mask;
  assign found = |cand;

  // lowest free live bit
  always_comb begin
    idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (cand[b]) idx = BIT_W'(b);
    end
  end

  assign onehot  = WORD_BITS'(1) << idx;
  assign hit     = (req_q == REQ_ALLOC) && found;
  assign fa_full = {ptr_q, idx, {FB_LOG2{1'b0}}};

  always_comb begin
    unique case (req_q)
      REQ_ALLOC: upd_word = rdata_q | onehot;
      REQ_FREE:  upd_word = rdata_q & ~act_mask;
      default:   upd_word = rdata_q | act_mask;
    endcase
  end

  assign mem_we = cmd_i.clear | (cmd_i.eval & ((req_q != REQ_ALLOC) | found));
  assign mem_wd = cmd_i.clear ? '0 : upd_word;

  // working result
  logic [ADDR_W-1:0] res_addr_q;
  logic              res_grant_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_addr_q  <= '0;
      res_grant_q <= 1'b0;
    end else if (cmd_i.eval && hit) begin
      res_addr_q  <= ADDR_W'(fa_full);
      res_grant_q <= 1'b1;
    end
  end

  // output register
  logic              out_valid_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic              out_grant_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_addr_q  <= res_addr_q;
      out_grant_q <= res_grant_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_address_o = out_addr_q;
  assign granted_o       = out_grant_q;

  assign status_o.clr_last = (ptr_q == LAST_WORD);
  assign status_o.empty    = empty_q;
  assign status_o.at_last  = (ptr_q == last_w_q);
  assign status_o.hit      = hit;
  assign status_o.out_free = ~out_valid_q | out_ready_i;

endmodule

// ===== hw/rtl/bitmap_frame_allocator.sv =====
// Bitmap frame allocator: one word in, one word out, one bitmap word scanned per cycle.
// The result goes to the output register after the scan of N bitmap words, N = words touched
// (allocate up to ceil(MAX_FRAMES / WORD_BITS), free 1, reserve the words covered, 0 when
// the request touches no frame); the next word is taken only once that result is published.
// Reset: asynchronous, active low; then a clearing pass zeroes all ceil(MAX_FRAMES / WORD_BITS)
// bitmap words before the first word is accepted. frame_count resets to 4096.
`timescale 1ns / 1ps

module bitmap_frame_allocator #(
  parameter int unsigned MAX_FRAMES  = 4096,  // frames in the bitmap
  parameter int unsigned FRAME_BYTES = 4096,  // power of two
  parameter int unsigned WORD_BITS   = 32     // bitmap word, power of two
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [63:0]                 s_axis_tdata,   // [31:0] address, [63:32] length_bytes
  input  logic [bfa_pkg::REQ_W-1:0]   s_axis_tuser,   // [1:0] req_type
  // result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [bfa_pkg::ADDR_W-1:0]  m_axis_tdata,   // [31:0] frame_address
  output logic                        m_axis_tuser,   // [0] granted
  // frame_count register write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bfa_pkg::CFG_W-1:0]   cfg_data_i
);
  import bfa_pkg::*;

  // frame_count register; writes must land only while idle (the block itself does not enforce it); always ready
  logic [CFG_W-1:0] frame_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FRAME_COUNT_RESET;
    end else if (cfg_valid_i) begin
      frame_count_q <= cfg_data_i;
    end
  end

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: clear pass, then accept -> setup -> check -> scan (skipped when empty) -> done
  bfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // bitmap memory and word logic; holds the output register
  bfa_datapath #(
    .MAX_FRAMES  (MAX_FRAMES),
    .FRAME_BYTES (FRAME_BYTES),
    .WORD_BITS   (WORD_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .req_type_i      (s_axis_tuser),
    .address_i       (s_axis_tdata[31:0]),
    .length_bytes_i  (s_axis_tdata[63:32]),
    .frame_count_i   (frame_count_q),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .frame_address_o (m_axis_tdata),
    .granted_o       (m_axis_tuser)
  );

endmodule
